### src/csa_pkg.sv
`default_nettype none
package csa_pkg;
  localparam int MaxSeg = 32;
  localparam int AddrBits = 20;
  localparam int OwnerBits = 8;
  localparam int IdxBits = $clog2(MaxSeg);
  localparam int CntBits = $clog2(MaxSeg + 1);
  localparam int SizeBits = 21;

  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_INIT    = 3'd0;
  localparam cmd_t CMD_REQUEST = 3'd1;
  localparam cmd_t CMD_RELEASE = 3'd2;
  localparam cmd_t CMD_COMPACT = 3'd3;
  localparam cmd_t CMD_STATUS  = 3'd4;

  typedef logic [2:0] stat_t;
  localparam stat_t ST_OK       = 3'd0;
  localparam stat_t ST_NO_HOLE  = 3'd1;
  localparam stat_t ST_NO_OWNER = 3'd2;
  localparam stat_t ST_FULL     = 3'd3;
  localparam stat_t ST_BAD_SIZE = 3'd4;

  typedef logic [1:0] fit_t;
  localparam fit_t FIT_BEST  = 2'd1;
  localparam fit_t FIT_WORST = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_SCAN, S_SPLIT, S_REL, S_MERGE, S_COMPACT, S_TOP, S_STATUS, S_OUT
  } state_t;

  typedef struct packed {
    logic [AddrBits-1:0]  first;
    logic [AddrBits-1:0]  last;
    logic                 used;
    logic [OwnerBits-1:0] owner;
  } seg_t;

  typedef struct packed {
    stat_t               status;
    seg_t                seg;
    logic                last_result;
  } res_t;
endpackage
`default_nettype wire

### src/csa_if.sv
`default_nettype none
interface csa_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] owner;
  logic [20:0] req_size;
  logic [1:0] fit_strategy;
  modport source (output valid, cmd, owner, req_size, fit_strategy, input ready);
  modport sink (input valid, cmd, owner, req_size, fit_strategy, output ready);
endinterface

interface csa_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [19:0] seg_first;
  logic [19:0] seg_last;
  logic        seg_in_use;
  logic [7:0]  seg_owner;
  logic        last_result;
  modport source (output valid, status, seg_first, seg_last, seg_in_use, seg_owner,
                  last_result, input ready);
  modport sink (input valid, status, seg_first, seg_last, seg_in_use, seg_owner,
                last_result, output ready);
endinterface
`default_nettype wire

### src/csa_ctrl.sv
`default_nettype none
module csa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire csa_pkg::cmd_t in_cmd,
  input  wire logic          dp_done,
  input  wire logic          res_pending,
  output csa_pkg::state_t    state
);
  import csa_pkg::*;
  state_t state_r, state_nxt;
  assign state = state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = !res_pending;
        if (in_valid && !res_pending) begin
          case (in_cmd)
            CMD_INIT:    state_nxt = S_INIT;
            CMD_REQUEST: state_nxt = S_SCAN;
            CMD_RELEASE: state_nxt = S_REL;
            CMD_COMPACT: state_nxt = S_COMPACT;
            CMD_STATUS:  state_nxt = S_STATUS;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN:    if (dp_done) state_nxt = S_SPLIT;
      S_SPLIT:   if (dp_done) state_nxt = S_OUT;
      S_REL:     if (dp_done) state_nxt = S_MERGE;
      S_MERGE:   if (dp_done) state_nxt = S_OUT;
      S_COMPACT: if (dp_done) state_nxt = S_TOP;
      S_TOP:     state_nxt = S_OUT;
      S_INIT:    state_nxt = S_OUT;
      S_STATUS:  if (dp_done) state_nxt = S_OUT;
      S_OUT:     if (!res_pending) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### src/csa_dp.sv
`default_nettype none
module csa_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire csa_pkg::state_t                    state,
  input  wire logic                               start,
  input  wire logic [7:0]                         in_owner,
  input  wire logic [20:0]                        in_req_size,
  input  wire logic [1:0]                         in_fit,
  input  wire logic                               cfg_we,
  input  wire logic [20:0]                        cfg_data,
  output logic                                    done,
  output logic                                    res_valid,
  input  wire logic                               res_ready,
  output csa_pkg::res_t                           res
);
  import csa_pkg::*;

  // table held in flops: shifts touch every entry each cycle at fixed places
  seg_t tab_r [MaxSeg];
  logic [CntBits-1:0] cnt_r;
  logic [20:0] total_r;
  logic [IdxBits-1:0] i_r;
  logic [CntBits-1:0] wr_r;        // compaction write index
  logic [AddrBits:0] next_r;       // compaction next free address
  logic found_r;
  logic [IdxBits-1:0] best_r;
  logic [AddrBits:0] blen_r;
  logic [OwnerBits-1:0] own_r;
  logic [20:0] size_r;
  fit_t fit_r;
  logic held_r;                    // released segment captured
  logic res_valid_r;
  res_t res_r;
  seg_t relseg_r;

  logic [AddrBits:0] space;
  logic [AddrBits:0] len_i;
  logic [AddrBits:0] last_new;
  logic scan_end;
  logic fits;

  assign space = (total_r == 21'd0) ? 21'd1 :
                 (total_r > 21'(1 << AddrBits)) ? 21'(1 << AddrBits) : total_r;
  assign len_i = {1'b0, tab_r[i_r].last} - {1'b0, tab_r[i_r].first} + 21'd1;
  assign fits = !tab_r[i_r].used && (len_i >= size_r);
  assign scan_end = ({1'b0, i_r} + CntBits'(1)) >= cnt_r;
  assign last_new = {1'b0, tab_r[best_r].first} + size_r - 21'd1;
  assign res_valid = res_valid_r;
  assign res = res_r;

  function automatic seg_t zseg();
    seg_t s;
    s = '0;
    return s;
  endfunction

  always_comb begin
    done = 1'b0;
    case (state)
      S_SCAN:    done = !fits ? scan_end :
                        (found_r ? scan_end : (fit_r == FIT_BEST || fit_r == FIT_WORST)
                         ? scan_end : 1'b1);
      S_SPLIT:   done = 1'b1;
      S_REL:     done = 1'b1;
      S_MERGE:   done = scan_end || cnt_r <= CntBits'(1);
      S_COMPACT: done = scan_end || cnt_r == '0;
      // done with the cycle that issues the last report transaction
      S_STATUS:  done = (!res_valid_r || res_ready) && (cnt_r == '0 || scan_end);
      default:   done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      total_r     <= 21'h100000;
      cnt_r       <= CntBits'(1);
      tab_r[0]    <= '{first: '0, last: '1, used: 1'b0, owner: '0};
      held_r      <= 1'b0;
      found_r     <= 1'b0;
      i_r         <= '0;
    end else begin
      if (res_valid_r && res_ready) res_valid_r <= 1'b0;
      if (cfg_we) total_r <= cfg_data;
      if (start) begin
        i_r <= '0; found_r <= 1'b0; own_r <= in_owner; size_r <= in_req_size;
        fit_r <= in_fit; wr_r <= '0; next_r <= '0; held_r <= 1'b0;
      end
      case (state)
        S_INIT: begin
          for (int k = 0; k < MaxSeg; k++) tab_r[k] <= zseg();
          tab_r[0].last <= AddrBits'(space - 21'd1);
          cnt_r <= CntBits'(1);
          res_r <= '{status: ST_OK, seg: zseg(), last_result: 1'b1};
          res_valid_r <= 1'b1;
        end
        S_SCAN: begin
          if (fits) begin
            if (!found_r) begin
              found_r <= 1'b1; best_r <= i_r; blen_r <= len_i;
            end else if ((fit_r == FIT_BEST && len_i < blen_r) ||
                         (fit_r == FIT_WORST && len_i > blen_r)) begin
              best_r <= i_r; blen_r <= len_i;
            end
          end
          if (!scan_end) i_r <= i_r + IdxBits'(1);
        end
        S_SPLIT: begin
          res_valid_r <= 1'b1;
          res_r <= '{status: ST_OK, seg: zseg(), last_result: 1'b1};
          if (size_r == '0) res_r.status <= ST_BAD_SIZE;
          else if (!found_r) res_r.status <= ST_NO_HOLE;
          else if (last_new < {1'b0, tab_r[best_r].last} &&
                   cnt_r >= CntBits'(MaxSeg)) res_r.status <= ST_FULL;
          else begin
            if (last_new < {1'b0, tab_r[best_r].last}) begin
              for (int k = 1; k < MaxSeg; k++)
                if (IdxBits'(k) > best_r && CntBits'(k) <= cnt_r) tab_r[k] <= tab_r[k-1];
              tab_r[best_r + IdxBits'(1)].first <= AddrBits'(last_new + 21'd1);
              tab_r[best_r + IdxBits'(1)].last  <= tab_r[best_r].last;
              tab_r[best_r + IdxBits'(1)].used  <= 1'b0;
              tab_r[best_r + IdxBits'(1)].owner <= '0;
              cnt_r <= cnt_r + CntBits'(1);
            end
            tab_r[best_r].last  <= AddrBits'(last_new);
            tab_r[best_r].used  <= 1'b1;
            tab_r[best_r].owner <= own_r;
            res_r.seg <= '{first: tab_r[best_r].first, last: AddrBits'(last_new),
                           used: 1'b1, owner: own_r};
          end
        end
        S_REL: begin
          // priority pick of the first owned entry
          found_r <= 1'b0;
          for (int k = MaxSeg - 1; k >= 0; k--)
            if (CntBits'(k) < cnt_r && tab_r[k].used && tab_r[k].owner == own_r) begin
              found_r <= 1'b1; best_r <= IdxBits'(k);
            end
          i_r <= '0;
        end
        S_MERGE: begin
          if (i_r == '0 && !held_r) begin
            held_r <= 1'b1;
            if (found_r) begin
              relseg_r <= '{first: tab_r[best_r].first, last: tab_r[best_r].last,
                            used: 1'b0, owner: '0};
              tab_r[best_r].used <= 1'b0; tab_r[best_r].owner <= '0;
            end
          end else if (!scan_end) begin
            if (!tab_r[i_r].used && !tab_r[i_r + IdxBits'(1)].used) begin
              tab_r[i_r].last <= tab_r[i_r + IdxBits'(1)].last;
              for (int k = 1; k < MaxSeg - 1; k++)
                if (IdxBits'(k) > i_r) tab_r[k] <= tab_r[k+1];
              tab_r[MaxSeg-1] <= zseg();
              cnt_r <= cnt_r - CntBits'(1);
            end else i_r <= i_r + IdxBits'(1);
          end
          if (done && (held_r || cnt_r <= CntBits'(1))) begin
            res_valid_r <= 1'b1;
            if (!found_r)
              res_r <= '{status: ST_NO_OWNER, seg: zseg(), last_result: 1'b1};
            else if (held_r)
              res_r <= '{status: ST_OK, seg: relseg_r, last_result: 1'b1};
            else begin
              res_r <= '{status: ST_OK, seg: '{first: tab_r[best_r].first,
                         last: tab_r[best_r].last, used: 1'b0, owner: '0},
                         last_result: 1'b1};
              tab_r[best_r].used <= 1'b0; tab_r[best_r].owner <= '0;
            end
          end
        end
        S_COMPACT: begin
          if (cnt_r != '0 && tab_r[i_r].used) begin
            tab_r[wr_r[IdxBits-1:0]] <= '{first: AddrBits'(next_r),
              last: AddrBits'(next_r + ({1'b0, tab_r[i_r].last} - {1'b0, tab_r[i_r].first})),
              used: 1'b1, owner: tab_r[i_r].owner};
            next_r <= next_r + ({1'b0, tab_r[i_r].last} - {1'b0, tab_r[i_r].first}) + 21'd1;
            wr_r <= wr_r + CntBits'(1);
          end
          if (!scan_end) i_r <= i_r + IdxBits'(1);
        end
        S_TOP: begin
          for (int k = 0; k < MaxSeg; k++)
            if (CntBits'(k) > wr_r) tab_r[k] <= zseg();
          if (next_r < space && wr_r < CntBits'(MaxSeg)) begin
            tab_r[wr_r[IdxBits-1:0]] <= '{first: AddrBits'(next_r),
              last: AddrBits'(space - 21'd1), used: 1'b0, owner: '0};
            cnt_r <= wr_r + CntBits'(1);
          end else begin
            if (wr_r < CntBits'(MaxSeg)) tab_r[wr_r[IdxBits-1:0]] <= zseg();
            cnt_r <= wr_r;
          end
          res_r <= '{status: ST_OK, seg: zseg(), last_result: 1'b1};
          res_valid_r <= 1'b1;
        end
        S_STATUS: begin
          if (!res_valid_r || res_ready) begin
            res_valid_r <= 1'b1;
            if (cnt_r == '0)
              res_r <= '{status: ST_OK, seg: zseg(), last_result: 1'b1};
            else begin
              res_r <= '{status: ST_OK, seg: '{first: tab_r[i_r].first,
                last: tab_r[i_r].last, used: tab_r[i_r].used,
                owner: tab_r[i_r].used ? tab_r[i_r].owner : '0},
                last_result: scan_end};
              if (!scan_end) i_r <= i_r + IdxBits'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

### src/contiguous_segment_allocator.sv
`default_nettype none
// Contiguous segment allocator. Keeps an address-sorted table of up to 32
// segments over a space of cfg total_size words. Commands: init, request
// (first/best/worst fit, ties to the earlier hole), release (first segment of
// the owner, then merge holes), compact, and status (one transaction per
// segment). Request, release, compact and status take one pass over the table,
// one entry per cycle, status only while the output is not back-pressured;
// init takes no pass and an unknown command is dropped. Write total_size only
// while idle.
module contiguous_segment_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  csa_in_if.sink           in_ch,
  csa_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [20:0] cfg_data
);
  import csa_pkg::*;
  state_t state;
  logic   dp_done, res_valid, start;
  res_t   res;

  // hold new commands until the previous result transaction is taken
  assign start = in_ch.valid && in_ch.ready;

  csa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_cmd(in_ch.cmd), .dp_done(dp_done), .res_pending(res_valid), .state(state)
  );

  csa_dp u_dp (
    .clk(clk), .rst_n(rst_n), .state(state), .start(start), .in_owner(in_ch.owner),
    .in_req_size(in_ch.req_size), .in_fit(in_ch.fit_strategy), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .done(dp_done), .res_valid(res_valid),
    .res_ready(out_ch.ready), .res(res)
  );

  assign out_ch.valid       = res_valid;
  assign out_ch.status      = res.status;
  assign out_ch.seg_first   = res.seg.first;
  assign out_ch.seg_last    = res.seg.last;
  assign out_ch.seg_in_use  = res.seg.used;
  assign out_ch.seg_owner   = res.seg.owner;
  assign out_ch.last_result = res.last_result;
endmodule
`default_nettype wire

### tb/contiguous_segment_allocator_test.sv
`default_nettype none
module contiguous_segment_allocator_test;
  import csa_pkg::*;

  localparam int unsigned SpaceMax = 1 << AddrBits;
  // Cycles to let the block settle after the last result; one full table pass
  // plus margin.
  localparam int SettleCycles = 100;
  // Cycles with no transaction on either channel before the run is abandoned.
  localparam int StallLimit = 6000;

  typedef struct {
    stat_t                status;
    logic [AddrBits-1:0]  lo;
    logic [AddrBits-1:0]  hi;
    logic                 used;
    logic [OwnerBits-1:0] owner;
    logic                 fin;
  } seg_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [20:0] cfg_data = '0;

  csa_in_if  in_ch ();
  csa_out_if out_ch ();

  contiguous_segment_allocator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow of the segment table, kept in address order.
  int unsigned          tbl_lo [MaxSeg];
  int unsigned          tbl_hi [MaxSeg];
  bit                   tbl_busy [MaxSeg];
  bit [OwnerBits-1:0]   tbl_own [MaxSeg];
  int                   tbl_count;
  bit [20:0]            space_words;

  seg_result_t expected_segs[$];

  int  mismatches = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  stall_cycles = 0;
  bit  no_idle = 1'b0;     // long stretch with neither side idling
  int  hold_req = 0;       // receiver hold-off request, in cycles
  int  hold_left = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned managed_span();
    if (space_words == 0) return 1;
    return (space_words > SpaceMax) ? SpaceMax : space_words;
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < MaxSeg; i++) begin
      tbl_lo[i] = 0; tbl_hi[i] = 0; tbl_busy[i] = 0; tbl_own[i] = 0;
    end
    tbl_hi[0] = managed_span() - 1;
    tbl_count = 1;
  endfunction

  function automatic void expect_seg(stat_t st, int unsigned lo, int unsigned hi,
                                     bit used, bit [OwnerBits-1:0] own, bit fin);
    seg_result_t r;
    r.status = st; r.lo = lo[AddrBits-1:0]; r.hi = hi[AddrBits-1:0];
    r.used = used; r.owner = own; r.fin = fin;
    expected_segs.push_back(r);
  endfunction

  function automatic void drop_entry(int idx);
    for (int i = idx; i + 1 < tbl_count; i++) begin
      tbl_lo[i] = tbl_lo[i+1]; tbl_hi[i] = tbl_hi[i+1];
      tbl_busy[i] = tbl_busy[i+1]; tbl_own[i] = tbl_own[i+1];
    end
    tbl_count--;
  endfunction

  function automatic void carve_segment(bit [7:0] own, bit [20:0] size, fit_t fit);
    int pick;
    int unsigned len, plen, lo, hi;
    pick = -1;
    if (size == 0) begin
      expect_seg(ST_BAD_SIZE, 0, 0, 0, 0, 1);
      return;
    end
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_busy[i]) continue;
      len = tbl_hi[i] - tbl_lo[i] + 1;
      if (len < size) continue;
      if (pick < 0) begin
        pick = i;
        if (fit != FIT_BEST && fit != FIT_WORST) break;
        continue;
      end
      plen = tbl_hi[pick] - tbl_lo[pick] + 1;
      if ((fit == FIT_BEST && len < plen) || (fit == FIT_WORST && len > plen)) pick = i;
    end
    if (pick < 0) begin
      expect_seg(ST_NO_HOLE, 0, 0, 0, 0, 1);
      return;
    end
    lo = tbl_lo[pick];
    hi = lo + size - 1;
    if (hi < tbl_hi[pick]) begin
      if (tbl_count >= MaxSeg) begin
        expect_seg(ST_FULL, 0, 0, 0, 0, 1);
        return;
      end
      for (int i = tbl_count; i > pick; i--) begin
        tbl_lo[i] = tbl_lo[i-1]; tbl_hi[i] = tbl_hi[i-1];
        tbl_busy[i] = tbl_busy[i-1]; tbl_own[i] = tbl_own[i-1];
      end
      tbl_count++;
      tbl_lo[pick+1] = hi + 1;
    end
    tbl_hi[pick] = hi;
    tbl_busy[pick] = 1;
    tbl_own[pick] = own;
    expect_seg(ST_OK, lo, hi, 1, own, 1);
  endfunction

  function automatic void free_segment(bit [7:0] own);
    int i;
    for (int k = 0; k < tbl_count; k++) begin
      if (tbl_busy[k] && tbl_own[k] == own) begin
        expect_seg(ST_OK, tbl_lo[k], tbl_hi[k], 0, 0, 1);
        tbl_busy[k] = 0;
        tbl_own[k] = 0;
        // merge neighboring holes
        i = 0;
        while (i + 1 < tbl_count) begin
          if (!tbl_busy[i] && !tbl_busy[i+1]) begin
            tbl_hi[i] = tbl_hi[i+1];
            drop_entry(i + 1);
          end else begin
            i++;
          end
        end
        return;
      end
    end
    expect_seg(ST_NO_OWNER, 0, 0, 0, 0, 1);
  endfunction

  function automatic void pack_table();
    int n;
    int unsigned nxt, len;
    n = 0;
    nxt = 0;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_busy[i]) begin
        len = tbl_hi[i] - tbl_lo[i];
        tbl_lo[n] = nxt; tbl_hi[n] = nxt + len;
        tbl_busy[n] = 1; tbl_own[n] = tbl_own[i];
        nxt = nxt + len + 1;
        n++;
      end
    end
    // leave the top hole out when the used segments fill the space or every entry is used
    if (nxt < managed_span() && n < MaxSeg) begin
      tbl_lo[n] = nxt; tbl_hi[n] = managed_span() - 1;
      tbl_busy[n] = 0; tbl_own[n] = 0;
      n++;
    end
    for (int i = n; i < MaxSeg; i++) begin
      tbl_lo[i] = 0; tbl_hi[i] = 0; tbl_busy[i] = 0; tbl_own[i] = 0;
    end
    tbl_count = n;
  endfunction

  function automatic void apply_command(cmd_t cmd, bit [7:0] own, bit [20:0] size,
                                        fit_t fit);
    case (cmd)
      CMD_INIT: begin
        clear_table();
        expect_seg(ST_OK, 0, 0, 0, 0, 1);
      end
      CMD_REQUEST: carve_segment(own, size, fit);
      CMD_RELEASE: free_segment(own);
      CMD_COMPACT: begin
        pack_table();
        expect_seg(ST_OK, 0, 0, 0, 0, 1);
      end
      CMD_STATUS: begin
        if (tbl_count == 0) expect_seg(ST_OK, 0, 0, 0, 0, 1);
        for (int i = 0; i < tbl_count; i++)
          expect_seg(ST_OK, tbl_lo[i], tbl_hi[i], tbl_busy[i],
                     tbl_busy[i] ? tbl_own[i] : 8'd0, i + 1 == tbl_count);
      end
      default: ;  // unknown commands are dropped without a result
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: randomly stall ready, honor hold-off requests, check results
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_idle || ($urandom_range(99) >= 32);
    end
  end

  always @(posedge clk) begin
    seg_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_segs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result status=%0d first=%0h last=%0h",
                   out_ch.status, out_ch.seg_first, out_ch.seg_last);
      end else begin
        want = expected_segs.pop_front();
        if (out_ch.status !== want.status || out_ch.seg_first !== want.lo ||
            out_ch.seg_last !== want.hi || out_ch.seg_in_use !== want.used ||
            out_ch.seg_owner !== want.owner || out_ch.last_result !== want.fin) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: result %0d exp st=%0d %0h..%0h use=%0b own=%0d fin=%0b",
                     results_seen, want.status, want.lo, want.hi, want.used,
                     want.owner, want.fin);
            $display("       got st=%0d %0h..%0h use=%0b own=%0d fin=%0b",
                     out_ch.status, out_ch.seg_first, out_ch.seg_last,
                     out_ch.seg_in_use, out_ch.seg_owner, out_ch.last_result);
          end
        end
      end
    end
  end

  // Watchdog: abandon the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("ERROR: no transaction for %0d cycles, %0d results outstanding",
               StallLimit, expected_segs.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared sender tasks; all of them start and end at a rising edge
  // ---------------------------------------------------------------------------
  task automatic send_cmd(cmd_t cmd, bit [7:0] own = '0, bit [20:0] size = '0,
                          fit_t fit = '0);
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.owner <= own;
    in_ch.req_size <= size;
    in_ch.fit_strategy <= fit;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    apply_command(cmd, own, size, fit);
    items_sent++;
    // idle the input between transactions now and then
    if (!no_idle && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Hold the sender until every expected result has come, then let the block
  // finish any work that produces no result.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_segs.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_space(bit [20:0] words);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= words;
    @(posedge clk);
    cfg_we <= 1'b0;
    space_words = words;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_basic_commands();
    send_cmd(CMD_STATUS);                          // one hole over the whole space
    send_cmd(CMD_REQUEST, 8'd1, 21'd0);            // zero size refused
    send_cmd(CMD_REQUEST, 8'd1, 21'h1FFFFF);       // larger than every hole
    send_cmd(CMD_REQUEST, 8'd255, 21'(SpaceMax), 2'd0); // exact fit, table stays at one
    send_cmd(CMD_STATUS);
    send_cmd(CMD_RELEASE, 8'd255);
    send_cmd(CMD_RELEASE, 8'd7);                   // owner not found
    send_cmd(CMD_REQUEST, 8'd0, 21'd100, 2'd0);
    send_cmd(CMD_REQUEST, 8'd2, 21'd50, 2'd3);
    send_cmd(CMD_REQUEST, 8'd3, 21'd100, 2'd0);
    send_cmd(CMD_REQUEST, 8'd4, 21'd30, 2'd1);
    send_cmd(CMD_RELEASE, 8'd0);                   // hole of 100 at the bottom
    send_cmd(CMD_RELEASE, 8'd4);                   // hole of 30 merges with top
    send_cmd(CMD_REQUEST, 8'd5, 21'd20, FIT_BEST); // best fit picks the 100 hole
    send_cmd(CMD_REQUEST, 8'd6, 21'd10, FIT_WORST);// worst fit picks the top hole
    send_cmd(CMD_RELEASE, 8'd3);                   // only used segments match
    send_cmd(CMD_STATUS);
    send_cmd(CMD_COMPACT);
    send_cmd(CMD_STATUS);
    send_cmd(cmd_t'(5));                           // unknown commands give nothing
    send_cmd(cmd_t'(6));
    send_cmd(cmd_t'(7), 8'hAA, 21'h155555, 2'd3);
    send_cmd(CMD_INIT);
  endtask

  // Fill the table to its limit, then run into table full and pack a full space.
  task automatic test_table_limit();
    write_space(21'd64);
    send_cmd(CMD_INIT);
    for (int i = 0; i < MaxSeg - 1; i++) send_cmd(CMD_REQUEST, 8'(i + 1), 21'd1, 2'd0);
    send_cmd(CMD_REQUEST, 8'd99, 21'd1);           // would split: table full
    send_cmd(CMD_REQUEST, 8'd99, 21'd40);          // no hole beats table full
    send_cmd(CMD_REQUEST, 8'd99, 21'd33, FIT_BEST);// exact fit still allowed
    send_cmd(CMD_STATUS);                          // all 32 entries
    send_cmd(CMD_RELEASE, 8'd5);
    send_cmd(CMD_RELEASE, 8'd6);
    send_cmd(CMD_REQUEST, 8'd77, 21'd2, FIT_WORST);
    send_cmd(CMD_COMPACT);                         // used segments fill the space
    send_cmd(CMD_STATUS);
  endtask

  task automatic test_space_extremes();
    write_space(21'd0);                            // clamps to one word
    send_cmd(CMD_INIT);
    send_cmd(CMD_REQUEST, 8'd1, 21'd2);
    send_cmd(CMD_REQUEST, 8'd1, 21'd1);
    send_cmd(CMD_COMPACT);
    send_cmd(CMD_STATUS);
    write_space(21'h1FFFFF);                       // clamps to the full address space
    send_cmd(CMD_INIT);
    send_cmd(CMD_REQUEST, 8'd9, 21'hFFFFF, FIT_WORST);
    send_cmd(CMD_STATUS);
    send_cmd(CMD_COMPACT);
    send_cmd(CMD_STATUS);
  endtask

  task automatic send_random_item(int unsigned span);
    int unsigned pick;
    bit [7:0] own;
    bit [20:0] size;
    pick = $urandom_range(99);
    own = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(15));
    if ($urandom_range(99) < 85)
      size = 21'($urandom_range(1, (span / 6 > 1) ? span / 6 : 1));
    else
      size = 21'($urandom_range(21'h1FFFFF));
    if (pick < 55)      send_cmd(CMD_REQUEST, own, size, fit_t'($urandom_range(3)));
    else if (pick < 84) send_cmd(CMD_RELEASE, own);
    else if (pick < 89) send_cmd(CMD_COMPACT);
    else if (pick < 95) send_cmd(CMD_STATUS);
    else if (pick < 97) send_cmd(CMD_INIT);
    else                send_cmd(cmd_t'($urandom_range(5, 7)), own, size);
  endtask

  task automatic test_random_mix();
    bit [20:0] spaces [4];
    spaces = '{21'd48, 21'($urandom_range(100, 5000)), 21'd1048576, 21'($urandom)};
    foreach (spaces[p]) begin
      write_space(spaces[p]);
      send_cmd(CMD_INIT);
      // the third phase runs with neither side idling
      no_idle = (p == 2);
      for (int i = 0; i < 40; i++) send_random_item(managed_span());
      no_idle = 1'b0;
    end
  endtask

  // Hold the receiver off while the sender keeps offering status reports so the
  // block backs up, then pause the sender until everything has drained.
  task automatic test_backpressure();
    write_space(21'd256);
    send_cmd(CMD_INIT);
    for (int i = 0; i < 8; i++) send_cmd(CMD_REQUEST, 8'(i), 21'd8, 2'd0);
    wait_idle();
    hold_req = 400;
    for (int i = 0; i < 6; i++) send_cmd(CMD_STATUS);
    send_cmd(CMD_RELEASE, 8'd3);
    send_cmd(CMD_COMPACT);
    wait_idle();
    send_cmd(CMD_STATUS);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_INIT;
    in_ch.owner = '0;
    in_ch.req_size = '0;
    in_ch.fit_strategy = '0;
    out_ch.ready = 1'b0;
    space_words = 21'd1048576;
    clear_table();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_commands();
    test_table_limit();
    test_space_extremes();
    test_backpressure();
    test_random_mix();

    wait_idle();
    if (expected_segs.size() != 0) mismatches++;
    $display("Sent %0d commands (init, first/best/worst fit, release, compact, status)",
             items_sent);
    $display("Checked %0d results over several space sizes incl. full table and stalls",
             results_seen);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
